### rtl/a64x_pkg.sv
// Shared types, decode constants and helpers for the A64 integer execute block.
// No dependencies; every other file in rtl/ except a64x_checker.sv imports this package.
package a64x_pkg;

   localparam int unsigned NumGpr = 31;
   localparam int unsigned RegIdxW = 5;
   localparam logic [RegIdxW-1:0] SpIndex = 5'd31;

   localparam logic [31:0] MovwMask   = 32'h1f80_0000;
   localparam logic [31:0] MovwMatch  = 32'h1280_0000;
   localparam logic [31:0] AddiMatch  = 32'h1100_0000;
   localparam logic [31:0] AddrMask   = 32'h1f20_0000;
   localparam logic [31:0] AddrMatch  = 32'h0b00_0000;
   localparam logic [31:0] LogMask    = 32'h1f00_0000;
   localparam logic [31:0] LogMatch   = 32'h0a00_0000;
   localparam logic [31:0] AdrMatch   = 32'h1000_0000;
   localparam logic [31:0] CselMask   = 32'h1fe0_0800;
   localparam logic [31:0] CselMatch  = 32'h1a80_0000;
   localparam logic [31:0] BMask      = 32'h7c00_0000;
   localparam logic [31:0] BMatch     = 32'h1400_0000;
   localparam logic [31:0] CbMask     = 32'h7e00_0000;
   localparam logic [31:0] CbMatch    = 32'h3400_0000;
   localparam logic [31:0] BcMask     = 32'hff00_0010;
   localparam logic [31:0] BcMatch    = 32'h5400_0000;
   localparam logic [31:0] BrMask     = 32'hffff_fc1f;
   localparam logic [31:0] BrMatch    = 32'hd61f_0000;
   localparam logic [31:0] BlrMatch   = 32'hd63f_0000;
   localparam logic [31:0] RetMatch   = 32'hd65f_0000;
   localparam logic [31:0] NopWord    = 32'hd503_201f;

   localparam logic [1:0] ShLsl = 2'd0;
   localparam logic [1:0] ShLsr = 2'd1;
   localparam logic [1:0] ShAsr = 2'd2;
   localparam logic [1:0] ShRor = 2'd3;

   localparam logic [1:0] MovN = 2'd0;
   localparam logic [1:0] MovBad = 2'd1;
   localparam logic [1:0] MovK = 2'd3;

   localparam logic [1:0] LogAnd = 2'd0;
   localparam logic [1:0] LogOrr = 2'd1;
   localparam logic [1:0] LogEor = 2'd2;
   localparam logic [1:0] LogAnds = 2'd3;

   typedef struct packed {
      logic                ok;
      logic [63:0]         next_pc;
      logic                branch;
      logic                wen;
      logic [RegIdxW-1:0]  widx;
      logic [63:0]         wval;
      logic [3:0]          nzcv;
   } exec_result_type;

   // The first read port serves rd for move-wide and compare-and-branch.
   function automatic logic port_a_uses_rd(logic [31:0] insn);
      return ((insn & MovwMask) == MovwMatch) || ((insn & CbMask) == CbMatch);
   endfunction

   function automatic logic cond_holds(logic [3:0] c, logic [3:0] f);
      logic t;
      unique case (c[3:1])
         3'd0: t = f[2];
         3'd1: t = f[1];
         3'd2: t = f[3];
         3'd3: t = f[0];
         3'd4: t = f[1] & ~f[2];
         3'd5: t = (f[3] == f[0]);
         3'd6: t = (f[3] == f[0]) & ~f[2];
         default: t = 1'b1;
      endcase
      if (c[0] && (c != 4'hf)) begin
         t = ~t;
      end
      return t;
   endfunction

endpackage

### rtl/a64x_regfile.sv
// General register file: 31 x 64-bit synchronous memory, two read ports, one write.
// Uses a64x_pkg; reads of an entry written in the same cycle are forwarded.
module a64x_regfile import a64x_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               ren,
   input  logic [RegIdxW-1:0] raddr_a,
   input  logic [RegIdxW-1:0] raddr_b,
   input  logic               we,
   input  logic [RegIdxW-1:0] waddr,
   input  logic [63:0]        wdata,
   output logic [63:0]        rdata_a,
   output logic [63:0]        rdata_b
);

   logic [63:0]        mem [NumGpr];
   logic [NumGpr-1:0]  written_ff;
   logic [63:0]        q_a_ff, q_b_ff, byp_ff;
   logic               vld_a_ff, vld_b_ff, hit_a_ff, hit_b_ff, zr_a_ff, zr_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         q_a_ff <= mem[raddr_a];
         q_b_ff <= mem[raddr_b];
         byp_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
         zr_a_ff <= 1'b1;
         zr_b_ff <= 1'b1;
      end else begin
         if (we) begin
            written_ff[waddr] <= 1'b1;
         end
         if (ren) begin
            zr_a_ff <= (raddr_a == SpIndex);
            zr_b_ff <= (raddr_b == SpIndex);
            vld_a_ff <= (raddr_a != SpIndex) && written_ff[raddr_a];
            vld_b_ff <= (raddr_b != SpIndex) && written_ff[raddr_b];
            hit_a_ff <= we && (waddr == raddr_a);
            hit_b_ff <= we && (waddr == raddr_b);
         end
      end
   end

   assign rdata_a = zr_a_ff ? 64'd0 : hit_a_ff ? byp_ff : vld_a_ff ? q_a_ff : 64'd0;
   assign rdata_b = zr_b_ff ? 64'd0 : hit_b_ff ? byp_ff : vld_b_ff ? q_b_ff : 64'd0;

endmodule

### rtl/a64x_exec.sv
// Instruction decode and integer datapath: shifter, adder, logic unit, branch targets.
// Uses a64x_pkg; operands come from a64x_regfile and the flag and stack pointer registers.
module a64x_exec import a64x_pkg::*; (
   input  logic [31:0]     insn,
   input  logic [63:0]     pc,
   input  logic [63:0]     opa,
   input  logic [63:0]     opb,
   input  logic [63:0]     sp,
   input  logic [3:0]      flags,
   output exec_result_type res
);

   logic               w64;
   logic [63:0]        wmask;
   logic [RegIdxW-1:0] rd, rn;
   logic               is_movw, is_addi, is_addr, is_log, is_adr, is_csel;
   logic               is_b, is_cb, is_bc, is_br, is_blr, is_ret;
   logic [1:0]         sh_kind;
   logic [5:0]         sh_amt;
   logic [63:0]        sh_in, sh_val;
   logic               sh_ok;
   logic               sub, setf;
   logic [63:0]        ar_a, ar_b, ar_r, v_vec;
   logic [3:0]         ar_flags;
   logic [63:0]        log_r;
   logic [5:0]         mw_sh;
   logic [63:0]        mw_imm, mw_val;
   logic [63:0]        adr_imm, adr_val;
   logic [63:0]        cs_val;
   logic [63:0]        off26, off19;

   assign w64 = insn[31];
   assign wmask = w64 ? '1 : 64'h0000_0000_ffff_ffff;
   assign rd = insn[4:0];
   assign rn = insn[9:5];

   assign is_movw = (insn & MovwMask) == MovwMatch;
   assign is_addi = (insn & MovwMask) == AddiMatch;
   assign is_addr = (insn & AddrMask) == AddrMatch;
   assign is_log  = (insn & LogMask) == LogMatch;
   assign is_adr  = (insn & LogMask) == AdrMatch;
   assign is_csel = (insn & CselMask) == CselMatch;
   assign is_b    = (insn & BMask) == BMatch;
   assign is_cb   = (insn & CbMask) == CbMatch;
   assign is_bc   = (insn & BcMask) == BcMatch;
   assign is_br   = (insn & BrMask) == BrMatch;
   assign is_blr  = (insn & BrMask) == BlrMatch;
   assign is_ret  = (insn & BrMask) == RetMatch;

   assign sh_kind = insn[23:22];
   assign sh_amt = insn[15:10];
   assign sh_ok = (sh_kind != ShRor) && (w64 || !sh_amt[5]);
   assign sh_in = w64 ? opb :
                  (sh_kind == ShAsr) ? {{32{opb[31]}}, opb[31:0]} : {32'd0, opb[31:0]};

   always_comb begin
      unique case (sh_kind)
         ShLsl: sh_val = sh_in << sh_amt;
         ShLsr: sh_val = sh_in >> sh_amt;
         default: sh_val = 64'($signed(sh_in) >>> sh_amt);
      endcase
      sh_val = sh_val & wmask;
   end

   assign sub = insn[30];
   assign setf = insn[29];
   assign ar_a = (is_addi && (rn == SpIndex) ? sp : opa) & wmask;
   assign ar_b = is_addi ? (insn[22] ? {40'd0, insn[21:10], 12'd0} : {52'd0, insn[21:10]})
                         : sh_val;
   assign ar_r = (sub ? ar_a - ar_b : ar_a + ar_b) & wmask;
   assign v_vec = sub ? ((ar_a ^ ar_b) & (ar_a ^ ar_r)) : (~(ar_a ^ ar_b) & (ar_a ^ ar_r));
   assign ar_flags = {w64 ? ar_r[63] : ar_r[31], ar_r == 64'd0,
                      sub ? (ar_a >= ar_b) : (ar_r < ar_a),
                      w64 ? v_vec[63] : v_vec[31]};

   always_comb begin
      unique case (insn[30:29])
         LogOrr: log_r = opa | sh_val;
         LogEor: log_r = opa ^ sh_val;
         default: log_r = opa & sh_val;
      endcase
      log_r = log_r & wmask;
   end

   assign mw_sh = {insn[22:21], 4'd0};
   assign mw_imm = {48'd0, insn[20:5]} << mw_sh;
   assign mw_val = ((insn[30:29] == MovK) ? ((opa & ~(64'hffff << mw_sh)) | mw_imm) :
                    (insn[30:29] == MovN) ? ~mw_imm : mw_imm) & wmask;

   assign adr_imm = {{43{insn[23]}}, insn[23:5], insn[30:29]};
   assign adr_val = w64 ? ((pc & ~64'hfff) + {adr_imm[51:0], 12'd0}) : pc + adr_imm;

   always_comb begin
      if (cond_holds(insn[15:12], flags)) begin
         cs_val = opa;
      end else if (insn[30] && insn[10]) begin
         cs_val = 64'd0 - opb;
      end else if (insn[30]) begin
         cs_val = ~opb;
      end else if (insn[10]) begin
         cs_val = opb + 64'd1;
      end else begin
         cs_val = opb;
      end
   end

   assign off26 = {{36{insn[25]}}, insn[25:0], 2'b00};
   assign off19 = {{43{insn[23]}}, insn[23:5], 2'b00};

   always_comb begin
      res.ok = 1'b1;
      res.next_pc = pc + 64'd4;
      res.branch = 1'b0;
      res.wen = 1'b0;
      res.widx = '0;
      res.wval = '0;
      res.nzcv = flags;
      priority if (is_movw) begin
         if (insn[30:29] == MovBad || (!w64 && insn[22])) begin
            res.ok = 1'b0;
         end else if (rd != SpIndex) begin
            res.wen = 1'b1;
            res.widx = rd;
            res.wval = mw_val;
         end
      end else if (is_addi) begin
         if (setf) begin
            res.nzcv = ar_flags;
         end
         if (rd != SpIndex || !setf) begin
            res.wen = 1'b1;
            res.widx = rd;
            res.wval = ar_r;
         end
      end else if (is_addr) begin
         if (!sh_ok) begin
            res.ok = 1'b0;
         end else begin
            if (setf) begin
               res.nzcv = ar_flags;
            end
            if (rd != SpIndex) begin
               res.wen = 1'b1;
               res.widx = rd;
               res.wval = ar_r;
            end
         end
      end else if (is_log) begin
         if (insn[21] || !sh_ok) begin
            res.ok = 1'b0;
         end else begin
            if (insn[30:29] == LogAnds) begin
               res.nzcv = {w64 ? log_r[63] : log_r[31], log_r == 64'd0, 2'b00};
            end
            if (rd != SpIndex) begin
               res.wen = 1'b1;
               res.widx = rd;
               res.wval = log_r;
            end
         end
      end else if (is_adr) begin
         if (rd != SpIndex) begin
            res.wen = 1'b1;
            res.widx = rd;
            res.wval = adr_val;
         end
      end else if (is_csel) begin
         if (insn[29]) begin
            res.ok = 1'b0;
         end else if (rd != SpIndex) begin
            res.wen = 1'b1;
            res.widx = rd;
            res.wval = cs_val & wmask;
         end
      end else if (is_b) begin
         res.branch = 1'b1;
         res.next_pc = pc + off26;
         if (w64) begin
            res.wen = 1'b1;
            res.widx = 5'd30;
            res.wval = pc + 64'd4;
         end
      end else if (is_cb) begin
         res.branch = 1'b1;
         if (((opa & wmask) != 64'd0) == insn[24]) begin
            res.next_pc = pc + off19;
         end
      end else if (is_bc) begin
         res.branch = 1'b1;
         if (cond_holds(insn[3:0], flags)) begin
            res.next_pc = pc + off19;
         end
      end else if (is_br || is_blr || is_ret) begin
         res.branch = 1'b1;
         res.next_pc = opa;
         if (is_blr) begin
            res.wen = 1'b1;
            res.widx = 5'd30;
            res.wval = pc + 64'd4;
         end
      end else if (insn == NopWord) begin
         res.ok = 1'b1;
      end else begin
         res.ok = 1'b0;
      end
      if (!res.ok) begin
         res.next_pc = pc;
      end
   end

endmodule

### rtl/arm64_integer_subset_execute.sv
// Top level of the A64 integer execute block: read stage, execute stage, result register.
// Uses a64x_pkg, a64x_regfile and a64x_exec.
//
// A request carries one instruction word and its fetch address on req_*; it is
// taken at a clock edge with req_valid high and req_stall low. The register file
// is read at that edge; the instruction then executes in the execute stage, and when
// that stage fires it updates X0-X30, SP and NZCV and its result moves into the rsp_*
// register. One request is accepted per cycle while results flow; a write to a
// register used by the following instruction is forwarded around the memory.
// When rsp_stall is high the result register holds, the execute stage holds one
// more request, and req_stall rises once that stage is full.
// Reset clears all registers, SP and the flags (the memory entries are marked
// unwritten and read as zero) and empties both stages; no clearing pass is needed.
module arm64_integer_subset_execute import a64x_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   input  logic [63:0] req_fetch_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [63:0] rsp_next_address,
   output logic        rsp_is_branch,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [63:0] rsp_reg_value,
   output logic [3:0]  rsp_nzcv
);

   logic            accept, fire;
   logic            s1_valid_ff;
   logic [31:0]     s1_insn_ff;
   logic [63:0]     s1_pc_ff;
   logic [63:0]     sp_ff;
   logic [3:0]      nzcv_ff;
   logic [63:0]     opa, opb;
   exec_result_type res;
   logic            out_valid_ff;
   exec_result_type out_ff;

   assign fire = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !fire;
   assign accept = req_valid && !req_stall;

   a64x_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .ren     (accept),
      .raddr_a (port_a_uses_rd(req_instruction) ? req_instruction[4:0]
                                                : req_instruction[9:5]),
      .raddr_b (req_instruction[20:16]),
      .we      (fire && res.wen && (res.widx != SpIndex)),
      .waddr   (res.widx),
      .wdata   (res.wval),
      .rdata_a (opa),
      .rdata_b (opb)
   );

   a64x_exec u_exec (
      .insn  (s1_insn_ff),
      .pc    (s1_pc_ff),
      .opa   (opa),
      .opb   (opb),
      .sp    (sp_ff),
      .flags (nzcv_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         sp_ff <= '0;
         nzcv_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            nzcv_ff <= res.nzcv;
            if (res.wen && res.widx == SpIndex) begin
               sp_ff <= res.wval;
            end
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_insn_ff <= req_instruction;
         s1_pc_ff <= req_fetch_address;
      end
      if (fire) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = !out_ff.ok;
   assign rsp_next_address = out_ff.next_pc;
   assign rsp_is_branch = out_ff.branch;
   assign rsp_reg_written = out_ff.wen;
   assign rsp_reg_index = out_ff.widx;
   assign rsp_reg_value = out_ff.wval;
   assign rsp_nzcv = out_ff.nzcv;

endmodule

### rtl/a64x_checker.sv
// Port-level checks for arm64_integer_subset_execute and the bind that attaches them.
// Depends only on the top level's ports.
module a64x_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic        rsp_is_branch,
   input logic        rsp_reg_written,
   input logic [4:0]  rsp_reg_index,
   input logic [63:0] rsp_reg_value,
   input logic [63:0] rsp_next_address
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_address))
      else $error("Stalled result changed.");

   a_unsup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_is_branch && !rsp_reg_written)
      else $error("Unsupported request reported side effects.");

   a_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_reg_index == 5'd0 && rsp_reg_value == 64'd0)
      else $error("Register fields set without a write.");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind arm64_integer_subset_execute a64x_checker u_a64x_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_is_branch    (rsp_is_branch),
   .rsp_reg_written  (rsp_reg_written),
   .rsp_reg_index    (rsp_reg_index),
   .rsp_reg_value    (rsp_reg_value),
   .rsp_next_address (rsp_next_address)
);

### tb/sv/tb_arm64_integer_subset_execute.sv
// Self-checking testbench for arm64_integer_subset_execute: directed and random A64 requests,
// checked against a built-in predictor of the registers, SP and flags under random idling and output stalls.
// Depends on a64x_pkg and the RTL of the block only.
module tb_arm64_integer_subset_execute import a64x_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        status;
      logic [63:0] next_address;
      logic        is_branch;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [63:0] reg_value;
      logic [3:0]  nzcv;
   } exec_outcome_type;

   localparam int unsigned CycleLimit = 400000;
   localparam logic [63:0] Low32 = 64'h0000_0000_ffff_ffff;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_instruction;
   logic [63:0] req_fetch_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_status;
   logic [63:0] rsp_next_address;
   logic        rsp_is_branch;
   logic        rsp_reg_written;
   logic [4:0]  rsp_reg_index;
   logic [63:0] rsp_reg_value;
   logic [3:0]  rsp_nzcv;

   logic [63:0]      gpr_model [NumGpr];
   logic [63:0]      sp_model;
   logic [3:0]       flags_model;
   exec_outcome_type pending_outcomes [$];
   int unsigned      error_count;
   int unsigned      cycle_count;
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   logic [63:0]      next_pc;

   arm64_integer_subset_execute dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_instruction(req_instruction),
      .req_fetch_address(req_fetch_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_next_address(rsp_next_address),
      .rsp_is_branch(rsp_is_branch),
      .rsp_reg_written(rsp_reg_written),
      .rsp_reg_index(rsp_reg_index),
      .rsp_reg_value(rsp_reg_value),
      .rsp_nzcv(rsp_nzcv)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("arm64_integer_subset_execute: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [63:0] sign_extend(logic [63:0] v, int bits);
      logic [63:0] sign;
      logic [63:0] mask;
      sign = 64'd1 << (bits - 1);
      mask = (64'd1 << bits) - 64'd1;
      return ((v & mask) ^ sign) - sign;
   endfunction

   function automatic logic [63:0] read_zero(logic [4:0] r);
      return (r == SpIndex) ? 64'd0 : gpr_model[r];
   endfunction

   function automatic logic [3:0] nz_of(logic [63:0] r, int top);
      return {r[top], r == 64'd0, 2'b00};
   endfunction

   function automatic logic [3:0] add_flags(logic [63:0] a, logic [63:0] b, logic [63:0] r,
                                            int top);
      logic [63:0] ov;
      ov = ~(a ^ b) & (a ^ r);
      return nz_of(r, top) | {2'b00, r < a, ov[top]};
   endfunction

   function automatic logic [3:0] sub_flags(logic [63:0] a, logic [63:0] b, logic [63:0] r,
                                            int top);
      logic [63:0] ov;
      ov = (a ^ b) & (a ^ r);
      return nz_of(r, top) | {2'b00, a >= b, ov[top]};
   endfunction

   function automatic logic condition_met(logic [3:0] c);
      logic t;
      case (c[3:1])
         3'd0: t = flags_model[2];
         3'd1: t = flags_model[1];
         3'd2: t = flags_model[3];
         3'd3: t = flags_model[0];
         3'd4: t = flags_model[1] & ~flags_model[2];
         3'd5: t = (flags_model[3] == flags_model[0]);
         3'd6: t = (flags_model[3] == flags_model[0]) & ~flags_model[2];
         default: t = 1'b1;
      endcase
      if (c[0] && c != 4'hf) begin
         t = ~t;
      end
      return t;
   endfunction

   function automatic logic shift_operand(inout logic [63:0] v, input logic [1:0] kind,
                                          input logic [5:0] amt, input logic w64);
      logic [63:0] x;
      if (kind == ShRor || (!w64 && amt >= 6'd32)) begin
         return 1'b0;
      end
      x = w64 ? v : ((kind == ShAsr) ? sign_extend(v, 32) : (v & Low32));
      case (kind)
         ShLsl: x = x << amt;
         ShLsr: x = x >> amt;
         default: x = $signed(x) >>> amt;
      endcase
      v = w64 ? x : (x & Low32);
      return 1'b1;
   endfunction

   function automatic void write_dest(inout exec_outcome_type o, input logic [4:0] r,
                                      input logic [63:0] v, input logic sp_ok);
      if (r != SpIndex) begin
         gpr_model[r] = v;
      end else if (sp_ok) begin
         sp_model = v;
      end else begin
         return;
      end
      o.reg_written = 1'b1;
      o.reg_index = r;
      o.reg_value = v;
   endfunction

   function automatic exec_outcome_type execute_insn(logic [31:0] insn, logic [63:0] pc);
      exec_outcome_type o;
      logic          ok;
      logic          w64;
      logic [63:0]   wmask;
      int            top;
      logic [4:0]    rd;
      logic [4:0]    rn;
      logic [4:0]    rm;
      logic [63:0]   a;
      logic [63:0]   b;
      logic [63:0]   r;
      logic [63:0]   imm;
      int            sh;
      ok = 1'b1;
      w64 = insn[31];
      wmask = w64 ? '1 : Low32;
      top = w64 ? 63 : 31;
      rd = insn[4:0];
      rn = insn[9:5];
      rm = insn[20:16];
      o = '0;
      o.next_address = pc + 64'd4;
      if ((insn & MovwMask) == MovwMatch) begin
         sh = insn[22:21] * 16;
         imm = {48'd0, insn[20:5]} << sh;
         if (insn[30:29] == MovBad || (!w64 && insn[22])) begin
            ok = 1'b0;
         end else begin
            if (insn[30:29] == MovK) begin
               r = (read_zero(rd) & ~(64'hffff << sh)) | imm;
            end else if (insn[30:29] == MovN) begin
               r = ~imm;
            end else begin
               r = imm;
            end
            write_dest(o, rd, r & wmask, 1'b0);
         end
      end else if ((insn & MovwMask) == AddiMatch) begin
         imm = {52'd0, insn[21:10]} << (insn[22] ? 12 : 0);
         a = ((rn == SpIndex) ? sp_model : gpr_model[rn]) & wmask;
         r = (insn[30] ? a - imm : a + imm) & wmask;
         if (insn[29]) begin
            flags_model = insn[30] ? sub_flags(a, imm, r, top) : add_flags(a, imm, r, top);
         end
         write_dest(o, rd, r, !insn[29]);
      end else if ((insn & AddrMask) == AddrMatch) begin
         b = read_zero(rm);
         if (!shift_operand(b, insn[23:22], insn[15:10], w64)) begin
            ok = 1'b0;
         end else begin
            a = read_zero(rn) & wmask;
            r = (insn[30] ? a - b : a + b) & wmask;
            if (insn[29]) begin
               flags_model = insn[30] ? sub_flags(a, b, r, top) : add_flags(a, b, r, top);
            end
            write_dest(o, rd, r, 1'b0);
         end
      end else if ((insn & LogMask) == LogMatch) begin
         b = read_zero(rm);
         if (insn[21] || !shift_operand(b, insn[23:22], insn[15:10], w64)) begin
            ok = 1'b0;
         end else begin
            a = read_zero(rn);
            case (insn[30:29])
               LogOrr: r = a | b;
               LogEor: r = a ^ b;
               default: r = a & b;
            endcase
            r = r & wmask;
            if (insn[30:29] == LogAnds) begin
               flags_model = nz_of(r, top);
            end
            write_dest(o, rd, r, 1'b0);
         end
      end else if ((insn & LogMask) == AdrMatch) begin
         imm = sign_extend({43'd0, insn[23:5], insn[30:29]}, 21);
         r = w64 ? (pc & ~64'hfff) + (imm << 12) : pc + imm;
         write_dest(o, rd, r, 1'b0);
      end else if ((insn & CselMask) == CselMatch) begin
         if (insn[29]) begin
            ok = 1'b0;
         end else begin
            if (condition_met(insn[15:12])) begin
               r = read_zero(rn);
            end else begin
               r = read_zero(rm);
               if (insn[30] && insn[10]) begin
                  r = 64'd0 - r;
               end else if (insn[30]) begin
                  r = ~r;
               end else if (insn[10]) begin
                  r = r + 64'd1;
               end
            end
            write_dest(o, rd, r & wmask, 1'b0);
         end
      end else if ((insn & BMask) == BMatch) begin
         o.is_branch = 1'b1;
         if (w64) begin
            write_dest(o, 5'd30, pc + 64'd4, 1'b0);
         end
         o.next_address = pc + (sign_extend({38'd0, insn[25:0]}, 26) << 2);
      end else if ((insn & CbMask) == CbMatch) begin
         o.is_branch = 1'b1;
         if (((read_zero(rd) & wmask) != 64'd0) == insn[24]) begin
            o.next_address = pc + (sign_extend({45'd0, insn[23:5]}, 19) << 2);
         end
      end else if ((insn & BcMask) == BcMatch) begin
         o.is_branch = 1'b1;
         if (condition_met(insn[3:0])) begin
            o.next_address = pc + (sign_extend({45'd0, insn[23:5]}, 19) << 2);
         end
      end else if ((insn & BrMask) == BrMatch || (insn & BrMask) == BlrMatch ||
                   (insn & BrMask) == RetMatch) begin
         a = read_zero(rn);
         o.is_branch = 1'b1;
         if ((insn & BrMask) == BlrMatch) begin
            write_dest(o, 5'd30, pc + 64'd4, 1'b0);
         end
         o.next_address = a;
      end else if (insn != NopWord) begin
         ok = 1'b0;
      end
      if (!ok) begin
         o = '0;
         o.status = 1'b1;
         o.next_address = pc;
      end
      o.nzcv = flags_model;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      exec_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result, next_address", rsp_next_address, '0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_next_address !== want.next_address)
               report_mismatch("next_address", rsp_next_address, want.next_address);
            if (rsp_is_branch !== want.is_branch)
               report_mismatch("is_branch", rsp_is_branch, want.is_branch);
            if (rsp_reg_written !== want.reg_written)
               report_mismatch("reg_written", rsp_reg_written, want.reg_written);
            if (rsp_reg_index !== want.reg_index)
               report_mismatch("reg_index", rsp_reg_index, want.reg_index);
            if (rsp_reg_value !== want.reg_value)
               report_mismatch("reg_value", rsp_reg_value, want.reg_value);
            if (rsp_nzcv !== want.nzcv)
               report_mismatch("nzcv", rsp_nzcv, want.nzcv);
         end
      end
   end

   // Called at a falling edge; returns at a falling edge once the request is taken.
   task automatic send_request(logic [31:0] insn, logic [63:0] pc);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_instruction <= insn;
      req_fetch_address <= pc;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      pending_outcomes.push_back(execute_insn(insn, pc));
      next_pc = pc + 64'd4;
      @(negedge clock);
   endtask

   task automatic send_next(logic [31:0] insn);
      send_request(insn, next_pc);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_outcomes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [31:0] random_insn();
      logic [31:0] w;
      logic [31:0] f;
      f = $urandom();
      case ($urandom_range(15))
         0: w = 32'h1280_0000 | (f & 32'he07f_ffff) | ($urandom_range(3) << 29);
         1: w = 32'h1100_0000 | (f & 32'he07f_ffff);
         2: w = 32'h0b00_0000 | (f & 32'he0df_0fff) | ($urandom_range(2) << 22)
                | ($urandom_range(31) << 10);
         3: w = 32'h0b00_0000 | (f & 32'he0df_ffff);
         4: w = 32'h0a00_0000 | (f & 32'he0df_0fff) | ($urandom_range(2) << 22)
                | ($urandom_range(31) << 10);
         5: w = 32'h0a00_0000 | (f & 32'he0ff_ffff);
         6: w = 32'h1000_0000 | (f & 32'he0ff_ffff);
         7: w = 32'h1a80_0000 | (f & 32'hc01f_f7ff);
         8: w = 32'h1a80_0000 | (f & 32'he01f_f7ff);
         9: w = 32'h1400_0000 | (f & 32'h83ff_ffff);
         10: w = 32'h3400_0000 | (f & 32'h81ff_ffff);
         11: w = 32'h5400_0000 | (f & 32'h00ff_ffef);
         12: w = ((($urandom_range(2) == 0) ? BrMatch :
                   ($urandom_range(1) == 0) ? BlrMatch : RetMatch)) | (f & 32'h0000_03e0);
         13: w = NopWord;
         default: w = f;
      endcase
      return w;
   endfunction

   task automatic test_moves();
      send_next(32'hd2ff_ffe1);
      send_next(32'h9280_0002);
      send_next(32'hf280_2461);
      send_next(32'h52c0_0003);
      send_next(32'h7280_0004);
      send_next(32'h12bf_ffe5);
   endtask

   task automatic test_arith();
      send_next(32'hb100_0443);
      send_next(32'h7100_007f);
      send_next(32'h9140_07ff);
      send_next(32'heb81_fc44);
      send_next(32'h2b02_0066);
      send_next(32'h8bc1_0047);
   endtask

   task automatic test_logic();
      send_next(32'hea01_0048);
      send_next(32'hca41_fc29);
      send_next(32'h2a00_000a);
      send_next(32'h8a21_000b);
   endtask

   task automatic test_addr_and_select();
      send_next(32'h70ff_ffec);
      send_next(32'h9000_000d);
      send_next(32'h9a82_102e);
      send_next(32'hda82_f42f);
      send_next(32'h3a82_0030);
   endtask

   task automatic test_branches();
      send_request(32'h9700_0000, 64'h0000_0000_0000_0000);
      send_next(32'h15ff_ffff);
      send_next(32'hb400_0020);
      send_next(32'h35ff_ffe1);
      send_next(32'h5400_002f);
      send_next(32'hd63f_03c0);
      send_next(32'hd65f_03c0);
      send_request(NopWord, '1);
      send_next(32'hf940_0000);
   endtask

   task automatic test_random();
      int unsigned phase;
      int unsigned n;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 82; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 82; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (n = 0; n < 235; n++) begin
            if (phase == 0 && n == 120) begin
               wait_drained();
            end
            if ($urandom_range(9) == 0) begin
               send_request(random_insn(), {$urandom(), $urandom()});
            end else begin
               send_next(random_insn());
            end
         end
      end
   endtask

   initial begin
      int unsigned i;
      for (i = 0; i < NumGpr; i++) begin
         gpr_model[i] = '0;
      end
      sp_model = '0;
      flags_model = '0;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      next_pc = 64'h0000_0000_0040_0000;
      reset = 1'b1;
      req_valid = 1'b0;
      req_instruction = '0;
      req_fetch_address = '0;
      rsp_stall = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_moves();
      test_arith();
      test_logic();
      test_addr_and_select();
      test_branches();
      test_random();
      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("arm64_integer_subset_execute: match");
      end else begin
         $display("arm64_integer_subset_execute: mismatch");
      end
      $finish;
   end

endmodule
